/* src/twc_pkg.sv */
// -----------------------------------------------------------------------------
// twc_pkg
// shared widths, register indexes and state codes of the weighted centroid unit
// -----------------------------------------------------------------------------
`default_nettype none

package twc_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int FRAC_BITS  = 8;

   localparam int PIX_W   = 8;
   localparam int SIZE_W  = 13;
   localparam int CNT_W   = 12;
   localparam int SUM_W   = 44;
   localparam int WSUM_W  = 32;
   localparam int CEN_W   = 20;
   localparam int OFF_W   = 21;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 4;

   // the dividend is sum << FRAC_BITS; its top WSUM_W bits seed the remainder
   localparam int DIVD_W    = SUM_W + FRAC_BITS;
   localparam int DIV_STEPS = DIVD_W - WSUM_W;
   localparam int LOW_SUM_W = DIV_STEPS - FRAC_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   localparam logic [SIZE_W-1:0] MAX_W_VAL = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_VAL = SIZE_W'(MAX_HEIGHT);

   localparam logic [PIX_W-1:0]  THRESH_RESET = PIX_W'(200);
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_WIDTH     = 2'd1,
      REG_HEIGHT    = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_DIV_X  = 5'b00100,
      ST_DIV_Y  = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* src/twc_if.sv */
// -----------------------------------------------------------------------------
// twc_req_if / twc_rsp_if
// valid/ready channels for pixel transactions and centroid transactions
// -----------------------------------------------------------------------------
`default_nettype none

interface twc_req_if import twc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface twc_rsp_if import twc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CEN_W-1:0]        centroid_x;
   logic [CEN_W-1:0]        centroid_y;
   logic signed [OFF_W-1:0] offset_x;
   logic signed [OFF_W-1:0] offset_y;
   logic                    frame_empty;

   modport source (output valid, output centroid_x, output centroid_y,
                   output offset_x, output offset_y, output frame_empty,
                   input ready);
   modport sink   (input valid, input centroid_x, input centroid_y,
                   input offset_x, input offset_y, input frame_empty,
                   output ready);
endinterface

`default_nettype wire

/* src/threshold_weighted_centroid_unit.sv */
// -----------------------------------------------------------------------------
// threshold_weighted_centroid_unit
// output: only the last pixel of a frame yields a result, through the load, x divide,
//   y divide and result states (load and result only for an empty frame)
// throughput: one pixel per cycle inside a frame; after the last pixel the input stalls
//   through load, both divides and result, which also waits for a free result slot
// reset: synchronous, active high; counters and sums zero, threshold 200, 640 x 480
// -----------------------------------------------------------------------------
`default_nettype none

module threshold_weighted_centroid_unit import twc_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   twc_req_if.sink            req,
   twc_rsp_if.source          rsp,
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire  [ADDR_W-1:0]  csr_paddr,
   input  wire  [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic [PIX_W-1:0]  thresh_ff, thresh_in;
   logic [SIZE_W-1:0] width_ff,  width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   reg_index_type     csr_index;
   logic              csr_write;

   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD: thresh_in = csr_pwdata[PIX_W-1:0];
            REG_WIDTH:     width_in  = csr_pwdata[SIZE_W-1:0];
            REG_HEIGHT:    height_in = csr_pwdata[SIZE_W-1:0];
            default: ;   // writes past the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_THRESHOLD: csr_prdata = DATA_W'(thresh_ff);
         REG_WIDTH:     csr_prdata = DATA_W'(width_ff);
         REG_HEIGHT:    csr_prdata = DATA_W'(height_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // effective frame size: zero reads as one, oversize clips to the maximum
   logic [SIZE_W-1:0] eff_w, eff_h;
   assign eff_w = (width_ff == '0)  ? SIZE_W'(1) :
                  (width_ff > MAX_W_VAL) ? MAX_W_VAL : width_ff;
   assign eff_h = (height_ff == '0) ? SIZE_W'(1) :
                  (height_ff > MAX_H_VAL) ? MAX_H_VAL : height_ff;

   // ---------------------------------------------------------------------------
   // pixel side: raster counters and accumulators
   // ---------------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [SUM_W-1:0]  sum_cx_ff, sum_cx_in;
   logic [SUM_W-1:0]  sum_cy_ff, sum_cy_in;
   logic [WSUM_W-1:0] sum_w_ff, sum_w_in;

   logic              req_take;
   logic [CNT_W-1:0]  col_base, row_base;
   logic [SUM_W-1:0]  cx_base, cy_base;
   logic [WSUM_W-1:0] w_base;
   logic [PIX_W+CNT_W-1:0] prod_col, prod_row;
   logic              bright;
   logic              row_end, frame_end;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;

   // frame_start drops whatever partial frame is in flight
   assign col_base = req.frame_start ? '0 : col_ff;
   assign row_base = req.frame_start ? '0 : row_ff;
   assign cx_base  = req.frame_start ? '0 : sum_cx_ff;
   assign cy_base  = req.frame_start ? '0 : sum_cy_ff;
   assign w_base   = req.frame_start ? '0 : sum_w_ff;

   assign bright   = req.pixel > thresh_ff;
   assign prod_col = req.pixel * col_base;
   assign prod_row = req.pixel * row_base;

   assign row_end   = ({1'b0, col_base} + SIZE_W'(1)) >= eff_w;
   assign frame_end = row_end && (({1'b0, row_base} + SIZE_W'(1)) >= eff_h);

   // ---------------------------------------------------------------------------
   // shared restoring divider: x quotient first, then y, one bit per cycle
   // the mean column or row stays below 2^CEN_W in fixed point, so the top
   // WSUM_W bits of the dividend are already smaller than the divisor
   // ---------------------------------------------------------------------------
   logic [WSUM_W-1:0] rem_ff, rem_in;
   logic [CEN_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CEN_W-1:0]  cx_ff, cx_in;
   logic              empty_ff, empty_in;

   logic [WSUM_W:0]   trial;
   logic              fits;
   logic [WSUM_W-1:0] rem_step;
   logic [CEN_W-1:0]  quo_step;

   assign trial    = {rem_ff, quo_ff[CEN_W-1]};
   assign fits     = trial >= {1'b0, sum_w_ff};
   assign rem_step = fits ? WSUM_W'(trial - {1'b0, sum_w_ff}) : trial[WSUM_W-1:0];
   assign quo_step = {quo_ff[CEN_W-2:0], fits};

   // ---------------------------------------------------------------------------
   // result slot
   // ---------------------------------------------------------------------------
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CEN_W-1:0]        out_cx_ff, out_cx_in;
   logic [CEN_W-1:0]        out_cy_ff, out_cy_in;
   logic signed [OFF_W-1:0] out_ox_ff, out_ox_in;
   logic signed [OFF_W-1:0] out_oy_ff, out_oy_in;
   logic                    out_empty_ff, out_empty_in;

   logic              slot_free;
   logic [CNT_W-1:0]  half_w, half_h;
   logic [CEN_W-1:0]  half_w_fx, half_h_fx;
   logic [SIZE_W-1:0] w_less, h_less;

   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign w_less    = eff_w - SIZE_W'(1);
   assign h_less    = eff_h - SIZE_W'(1);
   assign half_w    = w_less[SIZE_W-1:1];
   assign half_h    = h_less[SIZE_W-1:1];
   assign half_w_fx = {half_w, {FRAC_BITS{1'b0}}};
   assign half_h_fx = {half_h, {FRAC_BITS{1'b0}}};

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sum_cx_in    = sum_cx_ff;
      sum_cy_in    = sum_cy_ff;
      sum_w_in     = sum_w_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      cx_in        = cx_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_cx_in    = out_cx_ff;
      out_cy_in    = out_cy_ff;
      out_ox_in    = out_ox_ff;
      out_oy_in    = out_oy_ff;
      out_empty_in = out_empty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sum_cx_in = cx_base;
               sum_cy_in = cy_base;
               sum_w_in  = w_base;
               if (bright) begin
                  sum_cx_in = cx_base + SUM_W'(prod_col);
                  sum_cy_in = cy_base + SUM_W'(prod_row);
                  sum_w_in  = w_base + WSUM_W'(req.pixel);
               end
               if (frame_end) begin
                  col_in   = '0;
                  row_in   = '0;
                  state_in = ST_LOAD;
               end else if (row_end) begin
                  col_in = '0;
                  row_in = row_base + CNT_W'(1);
               end else begin
                  col_in = col_base + CNT_W'(1);
                  row_in = row_base;
               end
            end
         end
         ST_LOAD: begin
            // no pixel passed: skip the divide altogether
            empty_in = (sum_w_ff == '0);
            rem_in   = sum_cx_ff[SUM_W-1:LOW_SUM_W];
            quo_in   = {sum_cx_ff[LOW_SUM_W-1:0], {FRAC_BITS{1'b0}}};
            step_in  = '0;
            state_in = (sum_w_ff == '0) ? ST_RESULT : ST_DIV_X;
         end
         ST_DIV_X: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               cx_in    = quo_step;
               rem_in   = sum_cy_ff[SUM_W-1:LOW_SUM_W];
               quo_in   = {sum_cy_ff[LOW_SUM_W-1:0], {FRAC_BITS{1'b0}}};
               step_in  = '0;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // quo_ff holds the y quotient here
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_empty_in = empty_ff;
               if (empty_ff) begin
                  out_cx_in = '0;
                  out_cy_in = '0;
                  out_ox_in = '0;
                  out_oy_in = '0;
               end else begin
                  out_cx_in = cx_ff;
                  out_cy_in = quo_ff;
                  out_ox_in = $signed({1'b0, cx_ff} - {1'b0, half_w_fx});
                  out_oy_in = $signed({1'b0, half_h_fx} - {1'b0, quo_ff});
               end
               sum_cx_in = '0;
               sum_cy_in = '0;
               sum_w_in  = '0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         sum_cx_ff    <= '0;
         sum_cy_ff    <= '0;
         sum_w_ff     <= '0;
         step_ff      <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sum_cx_ff    <= sum_cx_in;
         sum_cy_ff    <= sum_cy_in;
         sum_w_ff     <= sum_w_in;
         step_ff      <= step_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cx_ff        <= cx_in;
      out_cx_ff    <= out_cx_in;
      out_cy_ff    <= out_cy_in;
      out_ox_ff    <= out_ox_in;
      out_oy_ff    <= out_oy_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.centroid_x  = out_cx_ff;
   assign rsp.centroid_y  = out_cy_ff;
   assign rsp.offset_x    = out_ox_ff;
   assign rsp.offset_y    = out_oy_ff;
   assign rsp.frame_empty = out_empty_ff;

endmodule

`default_nettype wire

/* sim/threshold_weighted_centroid_unit_tb.sv */
// -----------------------------------------------------------------------------
// threshold_weighted_centroid_unit_tb
// streams pixel transactions through the centroid unit under random source gaps
// and sink stalls, predicts each end-of-frame centroid transaction in the bench
// and compares every field; covers register extremes, size clamping, empty
// frames, restarts and frame size changes in the middle of a frame
// -----------------------------------------------------------------------------
`default_nettype none

module threshold_weighted_centroid_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import twc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 3;
   // margin after the last pixel and its result
   localparam int DRAIN_CYCLES   = 50;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PIXELS  = 880;
   // long run under an oversize frame before it is cut short
   localparam int CLAMP_RUN      = 300;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic [CEN_W-1:0]        centroid_x;
      logic [CEN_W-1:0]        centroid_y;
      logic signed [OFF_W-1:0] offset_x;
      logic signed [OFF_W-1:0] offset_y;
      logic                    frame_empty;
   } centroid_type;

   // brightness profile of a generated frame
   typedef enum int {
      TONE_UNIFORM,
      TONE_NEAR,
      TONE_DARK,
      TONE_EXTREME
   } tone_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   twc_req_if req_if ();
   twc_rsp_if rsp_if ();

   threshold_weighted_centroid_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // bench copy of the register file
   logic [PIX_W-1:0]  cfg_threshold;
   logic [SIZE_W-1:0] cfg_width;
   logic [SIZE_W-1:0] cfg_height;

   // bench copy of the frame tracking state
   int unsigned       pos_col;
   int unsigned       pos_row;
   logic [SUM_W-1:0]  acc_col;
   logic [SUM_W-1:0]  acc_row;
   logic [WSUM_W-1:0] acc_weight;

   pixel_item_type pixel_backlog[$];      // pixels waiting to be sent
   centroid_type   centroid_expected[$];  // predicted centroids, oldest first

   int  req_gap;
   int  rsp_stall;
   bit  steady;                        // no idling on either side while set
   int  mismatches;
   int  pixels_queued;
   int  pixels_taken;
   int  results_predicted;
   int  results_checked;
   int  empties_seen;
   int  settings_applied;
   int  quiet_cycles;

   // ---------------------------------------------------------------------------
   // centroid prediction
   // ---------------------------------------------------------------------------

   // zero size acts as one, oversize acts as the maximum
   function automatic int unsigned effective_size(input logic [SIZE_W-1:0] raw,
                                                  input int unsigned limit);
      if (raw == '0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   task automatic clear_frame_sums();
      pos_col    = 0;
      pos_row    = 0;
      acc_col    = '0;
      acc_row    = '0;
      acc_weight = '0;
   endtask

   task automatic predict_pixel(input pixel_item_type item);
      int unsigned  w;
      int unsigned  h;
      bit           row_end;
      bit           frame_end;
      bit [63:0]    quot_x;
      bit [63:0]    quot_y;
      bit [63:0]    half_w;
      bit [63:0]    half_h;
      bit [63:0]    diff_x;
      bit [63:0]    diff_y;
      centroid_type res;
      w = effective_size(cfg_width, MAX_WIDTH);
      h = effective_size(cfg_height, MAX_HEIGHT);
      // restart drops whatever partial frame was collected
      if (item.frame_start) clear_frame_sums();
      if (item.pixel > cfg_threshold) begin
         acc_col    = acc_col + SUM_W'(64'(item.pixel) * 64'(pos_col));
         acc_row    = acc_row + SUM_W'(64'(item.pixel) * 64'(pos_row));
         acc_weight = acc_weight + WSUM_W'(item.pixel);
      end
      // compare against the current size, so shrinking mid-frame ends rows early
      row_end   = (pos_col + 1) >= w;
      frame_end = row_end && ((pos_row + 1) >= h);
      if (!frame_end) begin
         if (row_end) begin
            pos_col = 0;
            pos_row++;
         end else begin
            pos_col++;
         end
      end else begin
         res = '0;
         if (acc_weight == '0) begin
            // nothing passed the threshold: all fields zero, flag set
            res.frame_empty = 1'b1;
         end else begin
            quot_x = (64'(acc_col) << FRAC_BITS) / 64'(acc_weight);
            quot_y = (64'(acc_row) << FRAC_BITS) / 64'(acc_weight);
            half_w = 64'((w - 1) / 2) << FRAC_BITS;
            half_h = 64'((h - 1) / 2) << FRAC_BITS;
            res.centroid_x = quot_x[CEN_W-1:0];
            res.centroid_y = quot_y[CEN_W-1:0];
            diff_x = 64'(res.centroid_x) - half_w;
            diff_y = half_h - 64'(res.centroid_y);
            res.offset_x = diff_x[OFF_W-1:0];
            res.offset_y = diff_y[OFF_W-1:0];
         end
         centroid_expected.push_back(res);
         results_predicted++;
         clear_frame_sums();
      end
   endtask

   // ---------------------------------------------------------------------------
   // idle lengths: mostly none or short, now and then a long one
   // ---------------------------------------------------------------------------
   function automatic int draw_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(99, 0);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // ---------------------------------------------------------------------------
   // pixel driver: presents the backlog head, holds it while the block stalls
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            // predict from what the block actually saw on the bus
            predict_pixel('{pixel: req_if.pixel, frame_start: req_if.frame_start});
            pixel_backlog.delete(0);
            pixels_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
               req_if.valid       <= 1'b1;
               req_if.pixel       <= pixel_backlog[0].pixel;
               req_if.frame_start <= pixel_backlog[0].frame_start;
               req_gap = draw_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // centroid monitor: random back-pressure, field by field comparison
   // ---------------------------------------------------------------------------
   task automatic report_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
   endtask

   task automatic check_centroid();
      centroid_type want;
      centroid_type got;
      got.centroid_x  = rsp_if.centroid_x;
      got.centroid_y  = rsp_if.centroid_y;
      got.offset_x    = rsp_if.offset_x;
      got.offset_y    = rsp_if.offset_y;
      got.frame_empty = rsp_if.frame_empty;
      if (centroid_expected.size() == 0) begin
         $display("%0t: centroid transaction expected none, got cx=%0d cy=%0d empty=%0b",
                  $time, got.centroid_x, got.centroid_y, got.frame_empty);
         mismatches++;
      end else begin
         want = centroid_expected.pop_front();
         if (got.centroid_x !== want.centroid_x)
            report_field("centroid_x", want.centroid_x, got.centroid_x);
         if (got.centroid_y !== want.centroid_y)
            report_field("centroid_y", want.centroid_y, got.centroid_y);
         if (got.offset_x !== want.offset_x)
            report_field("offset_x", want.offset_x, got.offset_x);
         if (got.offset_y !== want.offset_y)
            report_field("offset_y", want.offset_y, got.offset_y);
         if (got.frame_empty !== want.frame_empty)
            report_field("frame_empty", want.frame_empty, got.frame_empty);
         results_checked++;
         if (want.frame_empty) empties_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_centroid();
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_stall = draw_gap();
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long without any transaction or register access
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || csr_psel || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // register access over the apb port
   // ---------------------------------------------------------------------------
   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] data;
      data = value;
      // junk above the field must be dropped by the block
      if ($urandom_range(3, 0) == 0)
         data = data | ($urandom << ((idx == REG_THRESHOLD) ? PIX_W : SIZE_W));
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register taken at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_THRESHOLD: cfg_threshold = data[PIX_W-1:0];
         REG_WIDTH:     cfg_width     = data[SIZE_W-1:0];
         REG_HEIGHT:    cfg_height    = data[SIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic read_check_reg(input reg_index_type idx, input logic [DATA_W-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // sample read data at the end of the access cycle
      if (csr_prdata !== want) begin
         $display("%0t: register %s expected %0d, got %0d", $time, idx.name(), want,
                  csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_all_regs();
      read_check_reg(REG_THRESHOLD, DATA_W'(cfg_threshold));
      read_check_reg(REG_WIDTH, DATA_W'(cfg_width));
      read_check_reg(REG_HEIGHT, DATA_W'(cfg_height));
   endtask

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // every pixel sent, every centroid back, then let the divider settle
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || req_if.valid || centroid_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_frame(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] w,
                            input logic [DATA_W-1:0] h);
      wait_drained();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      check_all_regs();
      settings_applied++;
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic start);
      pixel_backlog.push_back('{pixel: pix, frame_start: start});
      pixels_queued++;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input tone_type tone);
      int t;
      int lo;
      int hi;
      t  = cfg_threshold;
      lo = (t < 2) ? 0 : t - 2;
      hi = (t > 253) ? 255 : t + 2;
      case (tone)
         TONE_NEAR:    return PIX_W'($urandom_range(hi, lo));
         TONE_DARK:    return PIX_W'($urandom_range(t, 0));
         TONE_EXTREME: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
         default:      return PIX_W'($urandom_range(255, 0));
      endcase
   endfunction

   task automatic queue_frame(input int count, input logic start, input tone_type tone);
      for (int i = 0; i < count; i++)
         push_pixel(pick_pixel(tone), (i == 0) ? start : 1'b0);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size(input int common_max);
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) return SIZE_W'($urandom_range(common_max, 1));
      if (roll < 88) return SIZE_W'($urandom_range(4 * common_max, common_max + 1));
      if (roll < 95) return '0;
      return SIZE_W'($urandom_range(64, 4 * common_max + 1));
   endfunction

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int       random_start;
      int       frame_len;
      int       n_frames;
      int       roll;
      int       thr_pick;
      int       left;
      int       len_cap;
      tone_type tone;

      // every input known from time zero
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.pixel       = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      steady             = 1'b0;
      mismatches         = 0;
      pixels_queued      = 0;
      pixels_taken       = 0;
      results_predicted  = 0;
      results_checked    = 0;
      empties_seen       = 0;
      settings_applied   = 0;
      quiet_cycles       = 0;
      cfg_threshold      = THRESH_RESET;
      cfg_width          = WIDTH_RESET;
      cfg_height         = HEIGHT_RESET;
      clear_frame_sums();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers come up at their reset values
      check_all_regs();

      // 3x2 frame at the reset threshold: extremes and both sides of the threshold
      wait_drained();
      write_reg(REG_WIDTH, 3);
      write_reg(REG_HEIGHT, 2);
      check_all_regs();
      push_pixel(8'd255, 1'b1);
      push_pixel(8'd0,   1'b0);
      push_pixel(8'd201, 1'b0);
      push_pixel(8'd200, 1'b0);
      push_pixel(8'd199, 1'b0);
      push_pixel(8'd255, 1'b0);

      // empty frame: nothing strictly above the threshold
      push_pixel(8'd200, 1'b1);
      push_pixel(8'd0,   1'b0);
      push_pixel(8'd100, 1'b0);
      push_pixel(8'd200, 1'b0);
      push_pixel(8'd3,   1'b0);
      push_pixel(8'd7,   1'b0);

      // restart inside a frame drops the partial sums
      push_pixel(8'd250, 1'b1);
      push_pixel(8'd240, 1'b0);
      push_pixel(8'd201, 1'b1);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd202, 1'b0);
      push_pixel(8'd0,   1'b0);
      push_pixel(8'd230, 1'b0);

      // zero sizes act as 1x1: every pixel closes a frame
      set_frame(0, 0, 0);
      push_pixel(8'd255, 1'b1);
      push_pixel(8'd0,   1'b0);
      push_pixel(8'd1,   1'b1);

      // top threshold: nothing can pass
      set_frame(255, 1, 1);
      push_pixel(8'd255, 1'b1);

      // oversize width clamps to the maximum: a long run never closes the row,
      // then a narrow width closes it with large column weights
      set_frame(128, 13'h1FFF, 1);
      queue_frame(CLAMP_RUN, 1'b1, TONE_UNIFORM);
      wait_drained();
      write_reg(REG_WIDTH, 2);
      queue_frame(1, 1'b0, TONE_UNIFORM);

      // height at the maximum with one-pixel rows, then cut to a single row
      set_frame(50, 1, MAX_HEIGHT);
      queue_frame(CLAMP_RUN, 1'b1, TONE_EXTREME);
      wait_drained();
      write_reg(REG_HEIGHT, 1);
      queue_frame(1, 1'b0, TONE_EXTREME);

      // width shrinks under a running frame: the current row ends at once
      set_frame(100, 5, 4);
      queue_frame(7, 1'b1, TONE_UNIFORM);
      wait_drained();
      write_reg(REG_WIDTH, 2);
      queue_frame(10, 1'b0, TONE_UNIFORM);

      // height shrinks below the current row: frame ends at the next row end
      set_frame(100, 4, 6);
      queue_frame(14, 1'b1, TONE_UNIFORM);
      wait_drained();
      write_reg(REG_HEIGHT, 2);
      queue_frame(8, 1'b0, TONE_UNIFORM);

      // write to the unused index changes nothing
      wait_drained();
      write_reg(REG_NONE, $urandom);
      check_all_regs();

      // random settings, mostly well-formed frames with some broken ones
      random_start = pixels_queued;
      while ((pixels_queued - random_start) < RANDOM_PIXELS) begin
         thr_pick = $urandom_range(9, 0);
         set_frame((thr_pick == 0) ? 0 : (thr_pick == 1) ? 255 : $urandom_range(255, 0),
                   pick_size(6), pick_size(4));
         if ($urandom_range(7, 0) == 0) write_reg(REG_NONE, $urandom);
         steady    = ($urandom_range(4, 0) == 0);
         frame_len = effective_size(cfg_width, MAX_WIDTH) *
                     effective_size(cfg_height, MAX_HEIGHT);
         n_frames  = $urandom_range(6, 2);
         repeat (n_frames) begin
            // keep the run near its pixel budget, a big frame may be cut short
            left = RANDOM_PIXELS - (pixels_queued - random_start);
            if (left > 0) begin
               len_cap = (frame_len < left) ? frame_len : left;
               roll    = $urandom_range(99, 0);
               tone    = tone_type'($urandom_range(3, 0));
               if (roll < 78)
                  queue_frame(len_cap, 1'b1, tone);
               else if (roll < 88)
                  // relies on the counters having wrapped to the frame start
                  queue_frame(len_cap, 1'b0, tone);
               else if (roll < 96)
                  // cut short, the next frame start restarts it
                  queue_frame($urandom_range(len_cap, 1), 1'b1, tone);
               else
                  queue_frame($urandom_range(4, 1), $urandom_range(1, 0), tone);
            end
         end
      end

      steady = 1'b0;
      wait_drained();

      $display("covered %0d pixel and %0d centroid transactions (%0d empty frames)",
               pixels_taken, results_checked, empties_seen);
      $display("over %0d register settings including clamped and zero frame sizes",
               settings_applied);
      if (mismatches == 0 && centroid_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
